### src/assert_macros.svh
// assertion macros shared by the list rtl
// both take a label and a clocked expression, sampled on clk with rst_n low disabling
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BLWS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("list assertion failed");
`define BLWS_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("list forbidden condition seen");
`else
`define BLWS_ASSERT(lbl, prop)
`define BLWS_NEVER(lbl, cond)
`endif
`endif

### src/blws_pkg.sv
// types and codes for the bounded list with search
// no dependencies
package blws_pkg;

  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 3;
  localparam int FOUND_W  = 4;
  localparam int COUNT_W  = 5;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam action_t ACT_PUSH_FRONT = 3'd0;
  localparam action_t ACT_PUSH_BACK  = 3'd1;
  localparam action_t ACT_POP_FRONT  = 3'd2;
  localparam action_t ACT_POP_BACK   = 3'd3;
  localparam action_t ACT_DELETE     = 3'd4;
  localparam action_t ACT_FIND       = 3'd5;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_EMPTY    = 3'd1;
  localparam status_t ST_BADPOS   = 3'd2;
  localparam status_t ST_FULL     = 3'd3;
  localparam status_t ST_NOTFOUND = 3'd4;

  // per-cell control struct
  typedef struct packed {
    logic ld_word;     // take the command word
    logic from_left;   // take the entry of the cell before
    logic from_right;  // take the entry of the cell after
    logic mark;        // compare entry with the word
    logic scan;        // hand match bits one cell toward the front
  } cell_ctl_t;

endpackage

### src/blws_ifs.sv
// valid/ready channels for commands and responses
// depends on blws_pkg
interface blws_cmd_if;
  logic                                   valid;
  logic                                   ready;
  logic [blws_pkg::ACTION_W-1:0]          action;
  logic signed [blws_pkg::VALUE_W-1:0]    value;
  logic [blws_pkg::POS_W-1:0]             position;

  modport source (output valid, action, value, position, input ready);
  modport sink (input valid, action, value, position, output ready);
endinterface

interface blws_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [blws_pkg::STATUS_W-1:0]  status;
  logic [blws_pkg::FOUND_W-1:0]   found_index;
  logic [blws_pkg::COUNT_W-1:0]   entry_count;

  modport source (output valid, status, found_index, entry_count, input ready);
  modport sink (input valid, status, found_index, entry_count, output ready);
endinterface

### src/blws_cell.sv
// one list cell: holds one entry and its match flag
// depends on blws_pkg for the control struct
module blws_cell #(
  parameter int WORD_BITS = 32
) (
  input  logic                  clk,
  input  blws_pkg::cell_ctl_t   ctl,
  input  logic                  valid,
  input  logic [WORD_BITS-1:0]  word,
  input  logic [WORD_BITS-1:0]  left_entry,
  input  logic [WORD_BITS-1:0]  right_entry,
  input  logic                  right_match,
  output logic [WORD_BITS-1:0]  entry,
  output logic                  match
);

  logic [WORD_BITS-1:0] entry_r;
  logic                 match_r;

  always_ff @(posedge clk) begin
    if (ctl.ld_word) begin
      entry_r <= word;
    end else if (ctl.from_left) begin
      entry_r <= left_entry;
    end else if (ctl.from_right) begin
      entry_r <= right_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mark) begin
      match_r <= valid && (entry_r == word);
    end else if (ctl.scan) begin
      match_r <= right_match;
    end
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

### src/bounded_list_with_search.sv
// bounded ordered list of signed words with search, built as a row of cells
// depends on blws_pkg, blws_ifs and blws_cell
//
//  channel   dir  word                               handshake
//  in_cmd    in   action, value, position            valid/ready
//  out_rsp   out  status, found_index, entry_count   valid/ready
//
// push, pop front and delete act on every cell in parallel; pop back only shrinks the count.
// find marks every cell holding the word, then the match flags walk toward cell 0 one cell
//   per cycle; the first flag at cell 0 gives the index, else no match once all entries pass.
// one command is in work at a time; a finished response sits in the output register.
// rst_n is synchronous: list empty, no response pending.
// out_rsp.ready low while a response is pending holds it and keeps in_cmd.ready low.
`include "assert_macros.svh"

module bounded_list_with_search #(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  blws_cmd_if.sink   in_cmd,
  blws_rsp_if.source out_rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                          state_r, state_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [IW-1:0]                 scan_r, scan_nxt;
  logic                          out_valid_r, out_valid_nxt;
  blws_pkg::status_t             out_status_r, out_status_nxt;
  logic [blws_pkg::FOUND_W-1:0]  out_found_r, out_found_nxt;
  logic [blws_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;

  logic                  accept, full, empty, pos_ok;
  logic                  do_pf, do_pb, do_popf, do_del, do_mark, do_scan;
  logic                  res_valid;
  logic [WORD_BITS-1:0]  word;

  logic [WORD_BITS-1:0]  entry_w [CAPACITY];
  logic                  match_w [CAPACITY];

  generate
    if (WORD_BITS <= blws_pkg::VALUE_W) begin : g_word_narrow
      assign word = in_cmd.value[WORD_BITS-1:0];
    end else begin : g_word_wide
      assign word = {{(WORD_BITS - blws_pkg::VALUE_W){1'b0}}, in_cmd.value};
    end
  endgenerate

  assign in_cmd.ready = (state_r == S_IDLE) && (!out_valid_r || out_rsp.ready);
  assign accept = in_cmd.valid && in_cmd.ready;
  assign full   = (count_r == CW'(CAPACITY));
  assign empty  = (count_r == '0);
  assign pos_ok = (32'(in_cmd.position) < 32'(count_r));

  assign do_pf   = accept && (in_cmd.action == blws_pkg::ACT_PUSH_FRONT) && !full;
  assign do_pb   = accept && (in_cmd.action == blws_pkg::ACT_PUSH_BACK) && !full;
  assign do_popf = accept && (in_cmd.action == blws_pkg::ACT_POP_FRONT) && !empty;
  assign do_del  = accept && (in_cmd.action == blws_pkg::ACT_DELETE) && !empty && pos_ok;
  assign do_mark = accept && (in_cmd.action == blws_pkg::ACT_FIND) && !empty;

  // cell row
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      blws_pkg::cell_ctl_t   ctl;
      logic [WORD_BITS-1:0]  left_e, right_e;
      logic                  right_m;

      if (gi == 0) begin : g_first
        assign left_e = '0;
      end else begin : g_mid_l
        assign left_e = entry_w[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_e = '0;
        assign right_m = 1'b0;
      end else begin : g_mid_r
        assign right_e = entry_w[gi+1];
        assign right_m = match_w[gi+1];
      end

      assign ctl.ld_word    = (do_pf && (gi == 0)) ||
                              (do_pb && (32'(gi) == 32'(count_r)));
      assign ctl.from_left  = do_pf && (gi != 0);
      assign ctl.from_right = do_popf || (do_del && (32'(gi) >= 32'(in_cmd.position)));
      assign ctl.mark       = do_mark;
      assign ctl.scan       = do_scan;

      blws_cell #(.WORD_BITS(WORD_BITS)) u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .valid       (32'(gi) < 32'(count_r)),
        .word        (word),
        .left_entry  (left_e),
        .right_entry (right_e),
        .right_match (right_m),
        .entry       (entry_w[gi]),
        .match       (match_w[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    do_scan        = 1'b0;
    res_valid      = 1'b0;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;

    if (state_r == S_IDLE) begin
      if (accept) begin
        res_valid      = 1'b1;
        out_status_nxt = blws_pkg::ST_OK;
        out_found_nxt  = '0;
        unique case (in_cmd.action)
          blws_pkg::ACT_PUSH_FRONT,
          blws_pkg::ACT_PUSH_BACK: begin
            if (full) begin
              out_status_nxt = blws_pkg::ST_FULL;
            end else begin
              count_nxt = count_r + 1'b1;
            end
          end
          blws_pkg::ACT_POP_FRONT,
          blws_pkg::ACT_POP_BACK: begin
            if (empty) begin
              out_status_nxt = blws_pkg::ST_EMPTY;
            end else begin
              count_nxt = count_r - 1'b1;
            end
          end
          blws_pkg::ACT_DELETE: begin
            if (empty) begin
              out_status_nxt = blws_pkg::ST_EMPTY;
            end else if (!pos_ok) begin
              out_status_nxt = blws_pkg::ST_BADPOS;
            end else begin
              count_nxt = count_r - 1'b1;
            end
          end
          blws_pkg::ACT_FIND: begin
            if (empty) begin
              out_status_nxt = blws_pkg::ST_NOTFOUND;
            end else begin
              // result comes once the match wave reaches cell 0 or every entry has passed
              res_valid = 1'b0;
              state_nxt = S_SCAN;
              scan_nxt  = '0;
            end
          end
          default: begin
          end
        endcase
      end
    end else begin
      if (match_w[0]) begin
        res_valid      = 1'b1;
        out_status_nxt = blws_pkg::ST_OK;
        out_found_nxt  = blws_pkg::FOUND_W'(scan_r);
        state_nxt      = S_IDLE;
      end else if ((CW'(scan_r) + 1'b1) >= count_r) begin
        res_valid      = 1'b1;
        out_status_nxt = blws_pkg::ST_NOTFOUND;
        out_found_nxt  = '0;
        state_nxt      = S_IDLE;
      end else begin
        do_scan  = 1'b1;
        scan_nxt = scan_r + 1'b1;
      end
    end

    out_count_nxt = res_valid ? blws_pkg::COUNT_W'(count_nxt) : out_count_r;
    out_valid_nxt = res_valid || (out_valid_r && !out_rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r       <= scan_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.found_index = out_found_r;
  assign out_rsp.entry_count = out_count_r;

  `BLWS_NEVER(a_count_bound, 32'(count_r) > 32'(CAPACITY))
  `BLWS_NEVER(a_no_accept_in_scan, (state_r == S_SCAN) && in_cmd.ready)
  `BLWS_NEVER(a_scan_in_range, (state_r == S_SCAN) && (32'(scan_r) >= 32'(count_r)))
  `BLWS_NEVER(a_scan_slot_free, (state_r == S_SCAN) && out_valid_r)
  `BLWS_ASSERT(a_push_grows, rst_n && do_pf |=> (count_r == $past(count_r) + 1'b1))

endmodule

### verif/tb_bounded_list_with_search.sv
`timescale 1ns / 100ps
// self-checking bench for bounded_list_with_search: directed corner commands, then random
// command streams checked against an in-bench list predictor; depends on blws_pkg and blws_ifs
module tb_bounded_list_with_search;
  import blws_pkg::*;

  localparam int CAP = 16;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 30;
  localparam int RANDOM_CMDS = 1600;
  // the two action codes the block leaves unused
  localparam action_t ACT_SPARE_A = 3'd6;
  localparam action_t ACT_SPARE_B = 3'd7;

  typedef struct packed {
    action_t             action;
    logic signed [31:0]  value;
    logic [POS_W-1:0]    position;
  } cmd_word_t;

  typedef struct packed {
    status_t             status;
    logic [FOUND_W-1:0]  found_index;
    logic [COUNT_W-1:0]  entry_count;
  } rsp_word_t;

  logic clk;
  logic rst_n;

  blws_cmd_if in_cmd ();
  blws_rsp_if out_rsp ();

  bounded_list_with_search #(
    .CAPACITY (CAP),
    .WORD_BITS(32)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_cmd (in_cmd),
    .out_rsp(out_rsp)
  );

  always #5 clk = ~clk;

  cmd_word_t pending_cmds[$];
  rsp_word_t expected_rsps[$];
  int        fail_count = 0;
  int        idle_cycles = 0;
  int        cycle_no = 0;
  bit        cmd_fire = 1'b0;

  // predicted list contents
  logic [31:0]        list_words[CAP];
  logic [3:0]         head = '0;
  logic [COUNT_W-1:0] fill = '0;

  function automatic logic [3:0] slot(int k);
    logic [3:0] s;
    s = head + k[3:0];
    return s;
  endfunction

  function automatic rsp_word_t apply_command(cmd_word_t c);
    rsp_word_t r;
    bit        hit;
    r.status = ST_OK;
    r.found_index = '0;
    hit = 1'b0;
    case (c.action)
      ACT_PUSH_FRONT: begin
        if (fill >= CAP) begin
          r.status = ST_FULL;
        end else begin
          head = head - 4'd1;
          list_words[head] = c.value;
          fill = fill + 1'b1;
        end
      end
      ACT_PUSH_BACK: begin
        if (fill >= CAP) begin
          r.status = ST_FULL;
        end else begin
          list_words[slot(fill)] = c.value;
          fill = fill + 1'b1;
        end
      end
      ACT_POP_FRONT: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          head = head + 4'd1;
          fill = fill - 1'b1;
        end
      end
      ACT_POP_BACK: begin
        if (fill == 0) r.status = ST_EMPTY;
        else fill = fill - 1'b1;
      end
      ACT_DELETE: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else if (c.position >= fill) begin
          r.status = ST_BADPOS;
        end else begin
          // close the gap toward the front
          for (int k = c.position; k + 1 < fill; k++)
            list_words[slot(k)] = list_words[slot(k + 1)];
          fill = fill - 1'b1;
        end
      end
      ACT_FIND: begin
        r.status = ST_NOTFOUND;
        for (int k = 0; k < fill; k++) begin
          if (!hit && list_words[slot(k)] == c.value) begin
            hit = 1'b1;
            r.status = ST_OK;
            r.found_index = k[3:0];
          end
        end
      end
      default: ;
    endcase
    r.entry_count = fill;
    return r;
  endfunction

  // stimulus side only tracks the count, to aim deletes and reach full/empty
  int gen_count = 0;

  task automatic add_cmd(action_t a, logic signed [31:0] v, logic [3:0] p);
    cmd_word_t c;
    c.action = a;
    c.value = v;
    c.position = p;
    pending_cmds.push_back(c);
    case (a)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: if (gen_count < CAP) gen_count++;
      ACT_POP_FRONT, ACT_POP_BACK: if (gen_count > 0) gen_count--;
      ACT_DELETE: if (p < gen_count) gen_count--;
      default: ;
    endcase
  endtask

  logic signed [31:0] value_pool[8] = '{32'sd0, -32'sd1, 32'sh7fffffff, 32'sh80000000,
                                        32'sd5, 32'sd17, -32'sd300, 32'sh0000ffff};

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(99) < 30) return $urandom;
    return value_pool[3'($urandom_range(7))];
  endfunction

  function automatic logic [3:0] pick_position();
    if (gen_count > 0 && $urandom_range(99) < 80) return 4'($urandom_range(gen_count - 1));
    return 4'($urandom_range(15));
  endfunction

  task automatic build_stimulus();
    int mode;
    int roll;
    int t[6];
    // empty list corners and unused codes, then a short list with boundary values
    add_cmd(ACT_POP_FRONT, 0, 0);
    add_cmd(ACT_POP_BACK, 0, 0);
    add_cmd(ACT_DELETE, 0, 0);
    add_cmd(ACT_FIND, 0, 0);
    add_cmd(ACT_SPARE_A, -1, 15);
    add_cmd(ACT_SPARE_B, 0, 0);
    add_cmd(ACT_PUSH_FRONT, 32'sh7fffffff, 0);
    add_cmd(ACT_PUSH_BACK, 32'sh80000000, 0);
    add_cmd(ACT_PUSH_FRONT, -1, 0);
    add_cmd(ACT_PUSH_BACK, 0, 0);
    add_cmd(ACT_FIND, 32'sh80000000, 0);
    add_cmd(ACT_FIND, 5, 0);
    add_cmd(ACT_DELETE, 0, 15);
    add_cmd(ACT_DELETE, 0, 0);
    add_cmd(ACT_DELETE, 0, 1);
    // fill up, then refused pushes at both ends
    for (int k = 0; k < CAP - 2; k++)
      add_cmd((k % 2) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, 100 + k, 0);
    add_cmd(ACT_PUSH_FRONT, 1, 0);
    add_cmd(ACT_PUSH_BACK, 2, 0);
    add_cmd(ACT_FIND, 100 + CAP - 3, 0);

    mode = 2;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n % 40 == 0) mode = $urandom_range(2);
      case (mode)
        0: t = '{30, 60, 68, 74, 82, 98};   // filling
        1: t = '{10, 20, 38, 54, 76, 98};   // draining
        default: t = '{20, 40, 52, 64, 78, 98};
      endcase
      roll = $urandom_range(99);
      if (roll < t[0]) add_cmd(ACT_PUSH_FRONT, pick_value(), 4'($urandom_range(15)));
      else if (roll < t[1]) add_cmd(ACT_PUSH_BACK, pick_value(), 4'($urandom_range(15)));
      else if (roll < t[2]) add_cmd(ACT_POP_FRONT, $urandom, 4'($urandom_range(15)));
      else if (roll < t[3]) add_cmd(ACT_POP_BACK, $urandom, 4'($urandom_range(15)));
      else if (roll < t[4]) add_cmd(ACT_DELETE, $urandom, pick_position());
      else if (roll < t[5]) add_cmd(ACT_FIND, pick_value(), 4'($urandom_range(15)));
      else add_cmd($urandom_range(1) ? ACT_SPARE_A : ACT_SPARE_B, $urandom,
                   4'($urandom_range(15)));
    end
  endtask

  // long stretch with no idling on either side
  function automatic bit steady();
    return cycle_no >= 1500 && cycle_no < 2500;
  endfunction

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_cmd.valid || cmd_fire) begin
        if (pending_cmds.size() > 0 && (steady() || $urandom_range(99) >= 10)) begin
          cmd_word_t c;
          c = pending_cmds.pop_front();
          in_cmd.valid <= 1'b1;
          in_cmd.action <= c.action;
          in_cmd.value <= c.value;
          in_cmd.position <= c.position;
        end else begin
          in_cmd.valid <= 1'b0;
        end
      end
      out_rsp.ready <= steady() || ($urandom_range(99) >= 10);
    end
  end

  always @(posedge clk) begin
    rsp_word_t got;
    rsp_word_t want;
    bit        rsp_fire;
    cycle_no <= cycle_no + 1;
    cmd_fire <= rst_n && in_cmd.valid && in_cmd.ready;
    rsp_fire = rst_n && out_rsp.valid && out_rsp.ready;
    if (rst_n && in_cmd.valid && in_cmd.ready)
      expected_rsps.push_back(apply_command({in_cmd.action, in_cmd.value, in_cmd.position}));
    if (rsp_fire) begin
      got = {out_rsp.status, out_rsp.found_index, out_rsp.entry_count};
      if (expected_rsps.size() == 0) begin
        $error("response word with nothing expected");
        fail_count++;
      end else begin
        want = expected_rsps.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fail_count++;
        end
        if (got.found_index !== want.found_index) begin
          $error("found_index: expected %0d, got %0d", want.found_index, got.found_index);
          fail_count++;
        end
        if (got.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
          fail_count++;
        end
      end
    end
    if ((rst_n && in_cmd.valid && in_cmd.ready) || rsp_fire) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_cmd.valid = 1'b0;
    in_cmd.action = ACT_PUSH_FRONT;
    in_cmd.value = '0;
    in_cmd.position = '0;
    out_rsp.ready = 1'b0;
    build_stimulus();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (pending_cmds.size() > 0 || in_cmd.valid) @(posedge clk);
    while (expected_rsps.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_rsps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### bounded_list_with_search.f
+incdir+src
src/blws_pkg.sv
src/blws_ifs.sv
src/blws_cell.sv
src/bounded_list_with_search.sv
verif/tb_bounded_list_with_search.sv
